// ----- rtl/pbd_pkg.sv -----
package pbd_pkg;

    // Preamble window size in bytes
    localparam int MAX_PREAMBLE_BYTES = 8;
    localparam int WIN_W              = 8 * MAX_PREAMBLE_BYTES;
    localparam int LEN_W              = 4;

    // Header byte positions and the shortest legal header
    localparam logic [LEN_W-1:0] HDR_ACTION_INDEX = 4'd0;
    localparam logic [LEN_W-1:0] HDR_LEN_INDEX    = 4'd2;
    localparam logic [LEN_W-1:0] HDR_MIN_LEN      = 4'd3;

    // Configuration register indexes
    localparam int CFG_INDEX_W = 2;
    localparam logic [CFG_INDEX_W-1:0] REG_PREAMBLE_PATTERN = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_PREAMBLE_LENGTH  = 2'd1;
    localparam logic [CFG_INDEX_W-1:0] REG_HEADER_LENGTH    = 2'd2;

    typedef enum logic [1:0] {
        PARSE_HUNT,
        PARSE_HEADER,
        PARSE_BODY
    } parse_mode_t;

endpackage

// ----- rtl/pbd_match.sv -----
module pbd_match
    import pbd_pkg::*;
(
    input  logic [WIN_W-1:0] window,      // window after the new byte
    input  logic [LEN_W-1:0] window_count, // count after the new byte
    input  logic [WIN_W-1:0] pattern,
    input  logic [LEN_W-1:0] preamble_length,
    output logic             hit
);

    logic [LEN_W-1:0] plen;
    logic [2:0]       shift_bytes;
    logic [WIN_W-1:0] seen;
    logic [WIN_W-1:0] mask;

    // Clamp preamble length into 1..MAX
    always_comb begin
        if (preamble_length == '0) begin
            plen = 4'd1;
        end else if (preamble_length > LEN_W'(MAX_PREAMBLE_BYTES)) begin
            plen = LEN_W'(MAX_PREAMBLE_BYTES);
        end else begin
            plen = preamble_length;
        end
    end

    // Newest plen bytes sit at the top of the window; bring them down
    assign shift_bytes = 3'(LEN_W'(MAX_PREAMBLE_BYTES) - plen);
    assign seen        = window >> {shift_bytes, 3'b000};

    // Byte mask for the compared bytes
    always_comb begin
        for (int i = 0; i < MAX_PREAMBLE_BYTES; i++) begin
            mask[8*i +: 8] = (LEN_W'(i) < plen) ? 8'hff : 8'h00;
        end
    end

    assign hit = (window_count >= plen) && (((seen ^ pattern) & mask) == '0);

endmodule

// ----- rtl/preamble_header_body_deframer.sv -----
// Output: a body byte accepted at one edge is registered and shows on m_* in the next cycle.
// Throughput: one byte per cycle; s_tready drops only while a result is
//   held and m_tready is low. Preamble and header bytes give no result.
// Reset: synchronous, active low; clears the parser to preamble hunting,
//   empties the window and output, and loads pattern 0, preamble length 8,
//   header length 4.
module preamble_header_body_deframer
    import pbd_pkg::*;
(
    input  logic                   aclk,
    input  logic                   aresetn,
    // configuration write port
    input  logic                   cfg_we,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [WIN_W-1:0]       cfg_wdata,
    // received bytes
    input  logic                   s_tvalid,
    output logic                   s_tready,
    input  logic [7:0]             s_tdata,   // [7:0] rx_byte
    // parsed body bytes
    output logic                   m_tvalid,
    input  logic                   m_tready,
    output logic [23:0]            m_tdata,   // [7:0] action_code, [15:8] body_length,
                                              // [23:16] body_byte
    output logic                   m_tuser,   // [0] empty_body
    output logic                   m_tlast    // last_byte
);

    // Configuration registers
    logic [WIN_W-1:0] pattern_reg;
    logic [LEN_W-1:0] pre_len_reg;
    logic [LEN_W-1:0] hdr_len_reg;

    // Parser state
    parse_mode_t      mode_reg, mode_next;
    logic [WIN_W-1:0] window_reg, window_next;
    logic [LEN_W-1:0] win_cnt_reg, win_cnt_next;
    logic [LEN_W-1:0] hdr_cnt_reg, hdr_cnt_next;
    logic [7:0]       action_reg, action_next;
    logic [7:0]       length_reg, length_next;
    logic [7:0]       body_cnt_reg, body_cnt_next;

    // Result register
    logic       out_valid_reg, out_valid_next;
    logic [7:0] out_action_reg, out_action_next;
    logic [7:0] out_length_reg, out_length_next;
    logic [7:0] out_byte_reg, out_byte_next;
    logic       out_empty_reg, out_empty_next;
    logic       out_last_reg, out_last_next;

    logic             accept;
    logic [WIN_W-1:0] shift_win;
    logic [LEN_W-1:0] shift_cnt;
    logic [LEN_W-1:0] hlen;
    logic [LEN_W-1:0] hdr_cnt_inc;
    logic [7:0]       body_cnt_inc;
    logic             hit;

    assign s_tready = !out_valid_reg || m_tready;
    assign accept   = s_tvalid && s_tready;

    // Window update while hunting
    assign shift_win = {s_tdata, window_reg[WIN_W-1:8]};
    assign shift_cnt = (win_cnt_reg < LEN_W'(MAX_PREAMBLE_BYTES)) ?
                       win_cnt_reg + 4'd1 : win_cnt_reg;

    pbd_match u_match (
        .window          (shift_win),
        .window_count    (shift_cnt),
        .pattern         (pattern_reg),
        .preamble_length (pre_len_reg),
        .hit             (hit)
    );

    assign hlen         = (hdr_len_reg < HDR_MIN_LEN) ? HDR_MIN_LEN : hdr_len_reg;
    assign hdr_cnt_inc  = hdr_cnt_reg + 4'd1;
    assign body_cnt_inc = body_cnt_reg + 8'd1;

    // Next state and result
    always_comb begin
        mode_next       = mode_reg;
        window_next     = window_reg;
        win_cnt_next    = win_cnt_reg;
        hdr_cnt_next    = hdr_cnt_reg;
        action_next     = action_reg;
        length_next     = length_reg;
        body_cnt_next   = body_cnt_reg;
        out_valid_next  = out_valid_reg && !m_tready;
        out_action_next = out_action_reg;
        out_length_next = out_length_reg;
        out_byte_next   = out_byte_reg;
        out_empty_next  = out_empty_reg;
        out_last_next   = out_last_reg;

        if (accept) begin
            unique case (mode_reg)
                PARSE_HEADER: begin
                    if (hdr_cnt_reg == HDR_ACTION_INDEX) begin
                        action_next = s_tdata;
                    end else if (hdr_cnt_reg == HDR_LEN_INDEX) begin
                        length_next = s_tdata;
                    end
                    hdr_cnt_next = hdr_cnt_inc;
                    if (hdr_cnt_inc >= hlen) begin
                        mode_next     = PARSE_BODY;
                        body_cnt_next = '0;
                    end
                end
                PARSE_BODY: begin
                    out_valid_next  = 1'b1;
                    out_action_next = action_reg;
                    out_length_next = length_reg;
                    if (length_reg == '0) begin
                        out_byte_next  = '0;
                        out_empty_next = 1'b1;
                        out_last_next  = 1'b1;
                    end else begin
                        out_byte_next  = s_tdata;
                        out_empty_next = 1'b0;
                        body_cnt_next  = body_cnt_inc;
                        out_last_next  = (body_cnt_inc == length_reg);
                    end
                    if (out_last_next) begin
                        mode_next    = PARSE_HUNT;
                        window_next  = '0;
                        win_cnt_next = '0;
                    end
                end
                default: begin
                    // hunting
                    mode_next    = PARSE_HUNT;
                    window_next  = shift_win;
                    win_cnt_next = shift_cnt;
                    if (hit) begin
                        window_next  = '0;
                        win_cnt_next = '0;
                        hdr_cnt_next = '0;
                        mode_next    = PARSE_HEADER;
                    end
                end
            endcase
        end
    end

    // Configuration writes
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pattern_reg <= '0;
            pre_len_reg <= LEN_W'(MAX_PREAMBLE_BYTES);
            hdr_len_reg <= 4'd4;
        end else if (cfg_we) begin
            unique case (cfg_index)
                REG_PREAMBLE_PATTERN: pattern_reg <= cfg_wdata;
                REG_PREAMBLE_LENGTH:  pre_len_reg <= cfg_wdata[LEN_W-1:0];
                REG_HEADER_LENGTH:    hdr_len_reg <= cfg_wdata[LEN_W-1:0];
                default: ;
            endcase
        end
    end

    // Parser state and control
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mode_reg      <= PARSE_HUNT;
            window_reg    <= '0;
            win_cnt_reg   <= '0;
            hdr_cnt_reg   <= '0;
            action_reg    <= '0;
            length_reg    <= '0;
            body_cnt_reg  <= '0;
            out_valid_reg <= 1'b0;
        end else begin
            mode_reg      <= mode_next;
            window_reg    <= window_next;
            win_cnt_reg   <= win_cnt_next;
            hdr_cnt_reg   <= hdr_cnt_next;
            action_reg    <= action_next;
            length_reg    <= length_next;
            body_cnt_reg  <= body_cnt_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Result payload
    always_ff @(posedge aclk) begin
        out_action_reg <= out_action_next;
        out_length_reg <= out_length_next;
        out_byte_reg   <= out_byte_next;
        out_empty_reg  <= out_empty_next;
        out_last_reg   <= out_last_next;
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {out_byte_reg, out_length_reg, out_action_reg};
    assign m_tuser  = out_empty_reg;
    assign m_tlast  = out_last_reg;

endmodule

// ----- rtl/pbd_checker.sv -----
module pbd_checker
    import pbd_pkg::*;
(
    input logic        aclk,
    input logic        aresetn,
    input logic        s_tready,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [23:0] m_tdata,
    input logic        m_tuser,
    input logic        m_tlast
);

    // Stalled result holds
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast))
        else $error("stalled transfer changed");

    // Output register free means input side is open
    assert property (@(posedge aclk) disable iff (!aresetn)
        !m_tvalid |-> s_tready)
        else $error("input stalled with empty output");

    // Empty body is a single last result with a zero byte
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser |-> m_tlast && (m_tdata[23:16] == 8'd0)
            && (m_tdata[15:8] == 8'd0))
        else $error("bad empty-body result");

    // Reset empties the output
    assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("result valid after reset");

endmodule

bind preamble_header_body_deframer pbd_checker u_pbd_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .m_tlast  (m_tlast)
);
